/* sv/ctp_pkg.sv */
// Package for the countdown timer pool: sizes, request codes and the slot record.
`timescale 1ns / 1ps
`default_nettype none

package ctp_pkg;

  localparam int NUM_SLOTS   = 8;
  localparam int NUM_HANDLES = 16;

  localparam int HANDLE_W = 4;
  localparam int TICK_W   = 32;
  localparam int DUR_W    = 16;

  localparam int SLOT_CNT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam logic [DUR_W-1:0] NO_EXPIRY = '1;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NEXT  = 2'd3
  } req_t;

  typedef struct packed {
    logic                valid;
    logic [HANDLE_W-1:0] handle;
    logic [TICK_W-1:0]   start;
  } slot_t;

  function automatic logic handle_in_range(input logic [HANDLE_W-1:0] id);
    return {1'b0, id} < (HANDLE_W + 1)'(NUM_HANDLES);
  endfunction

endpackage

`default_nettype wire

/* sv/ctp_cell.sv */
// One timer slot cell of the rotating slot chain.
`timescale 1ns / 1ps
`default_nettype none

module ctp_cell
  import ctp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  shift,
  input  wire slot_t slot_in,
  output slot_t      slot_out
);

  logic              valid_r;
  logic [HANDLE_W-1:0] handle_r;
  logic [TICK_W-1:0] start_r;

  // Only the valid bit is cleared; handle and start are read only when valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift) begin
      valid_r <= slot_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      handle_r <= slot_in.handle;
      start_r  <= slot_in.start;
    end
  end

  assign slot_out = '{valid: valid_r, handle: handle_r, start: start_r};

endmodule

`default_nettype wire

/* sv/countdown_timer_pool.sv */
// Top level of the countdown timer pool: request control, handle store and slot chain.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   An item is taken at a rising edge where start is high and busy is low. Its fields are
//   in_req_type (tick, start timer, query elapsed, next expiration), in_timer_id and in_ticks.
//   Every item produces exactly one result: out_valid is high for one cycle with out_ok,
//   out_is_elapsed and out_next_ticks; the fields that do not belong to the request read zero.
//   The receiver cannot stall, so a result must be taken in the cycle it is shown.
// Sequencing
//   A tick, a restart of a running handle and a start on a handle out of range answer in the
//   cycle after acceptance. A start on an idle handle and a next-expiration request walk the
//   slot chain once and answer when the walk ends; an elapsed query reads the handle's
//   duration in a finish state after its retirement pass. The walk is set by the chain of
//   slot cells rotating past a single evaluation point, one slot per cycle. busy is high
//   during the walk and the finish state, and a new item may be offered in the cycle its
//   predecessor's result is shown.
// Reset
//   rst_n is synchronous and active low. It clears the tick count, all handle durations and
//   all slot valid bits, and returns the controller to idle. No clearing pass is needed.

module countdown_timer_pool
  import ctp_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,

  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          in_req_type,
  input  wire logic [HANDLE_W-1:0] in_timer_id,
  input  wire logic [DUR_W-1:0]    in_ticks,

  output logic                     out_valid,
  output logic                     out_ok,
  output logic                     out_is_elapsed,
  output logic [DUR_W-1:0]         out_next_ticks
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  req_t   op_r, op_nxt;

  logic [HANDLE_W-1:0]   hid_r, hid_nxt;
  logic [SLOT_CNT_W-1:0] scan_cnt_r, scan_cnt_nxt;
  logic                  claimed_r, claimed_nxt;
  logic [DUR_W-1:0]      best_r, best_nxt;
  logic [TICK_W-1:0]     tick_now_r, tick_now_nxt;

  // Handle durations: a zero duration marks the handle as idle or elapsed.
  logic [DUR_W-1:0] dur_r [NUM_HANDLES];

  logic                out_valid_r, out_valid_nxt;
  logic                out_ok_r, out_ok_nxt;
  logic                out_is_elapsed_r, out_is_elapsed_nxt;
  logic [DUR_W-1:0]    out_next_ticks_r, out_next_ticks_nxt;

  // Slot chain: cell 0 is the evaluation point and the processed slot re-enters at the tail,
  // so after NUM_SLOTS shifts every slot is back in its own cell, visited in slot order.
  slot_t slot_q [NUM_SLOTS];
  slot_t head, head_ret;
  logic  shift;

  logic                rd_in_range;
  logic [HANDLE_W-1:0] rd_addr;
  logic [DUR_W-1:0]    rd_dur;
  logic [TICK_W-1:0]   diff;
  logic [DUR_W-1:0]    el, rem;
  logic                expired;
  logic                last;
  logic                accept;

  logic                wr_en;
  logic [HANDLE_W-1:0] wr_addr;
  logic [DUR_W-1:0]    wr_data;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);
  assign shift  = (state_r == ST_SCAN);
  assign head   = slot_q[0];
  assign last   = (scan_cnt_r == SLOT_CNT_W'(NUM_SLOTS - 1));

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    slot_t cell_in;
    if (i == NUM_SLOTS - 1) begin : g_tail
      assign cell_in = head_ret;
    end else begin : g_mid
      assign cell_in = slot_q[i + 1];
    end
    ctp_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift    (shift),
      .slot_in  (cell_in),
      .slot_out (slot_q[i])
    );
  end

  // One read port on the handle store: the slot at the head while walking the chain,
  // otherwise the requested handle.
  always_comb begin
    case (state_r)
      ST_SCAN:   rd_addr = head.handle;
      ST_FINISH: rd_addr = hid_r;
      default:   rd_addr = in_timer_id;
    endcase
    rd_in_range = handle_in_range(rd_addr);
    rd_dur      = rd_in_range ? dur_r[rd_addr] : '0;
  end

  // Elapsed ticks of the head slot; a wrapped tick count counts as nothing elapsed.
  assign diff    = tick_now_r - head.start;
  assign el      = (tick_now_r < head.start) ? '0 : diff[DUR_W-1:0];
  assign rem     = (el > rd_dur) ? '0 : (rd_dur - el);
  assign expired = head.valid && (el >= rd_dur);

  always_comb begin
    state_nxt          = state_r;
    op_nxt             = op_r;
    hid_nxt            = hid_r;
    scan_cnt_nxt       = scan_cnt_r;
    claimed_nxt        = claimed_r;
    best_nxt           = best_r;
    tick_now_nxt       = tick_now_r;
    head_ret           = head;
    wr_en              = 1'b0;
    wr_addr            = rd_addr;
    wr_data            = '0;
    out_valid_nxt      = 1'b0;
    out_ok_nxt         = 1'b0;
    out_is_elapsed_nxt = 1'b0;
    out_next_ticks_nxt = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt       = req_t'(in_req_type);
          hid_nxt      = in_timer_id;
          scan_cnt_nxt = '0;
          claimed_nxt  = 1'b0;
          best_nxt     = NO_EXPIRY;
          case (req_t'(in_req_type))
            REQ_TICK: begin
              tick_now_nxt  = tick_now_r + 1'b1;
              out_valid_nxt = 1'b1;
            end
            REQ_START: begin
              if (!rd_in_range) begin
                out_valid_nxt = 1'b1;
              end else begin
                wr_en   = 1'b1;
                wr_data = in_ticks;
                if (rd_dur != '0) begin
                  // Running handle: only its duration changes.
                  out_valid_nxt = 1'b1;
                  out_ok_nxt    = 1'b1;
                end else begin
                  state_nxt = ST_SCAN;
                end
              end
            end
            default: begin
              state_nxt = ST_SCAN;
            end
          endcase
        end
      end

      ST_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + 1'b1;
        case (op_r)
          REQ_START: begin
            if (!head.valid && !claimed_r) begin
              head_ret    = '{valid: 1'b1, handle: hid_r, start: tick_now_r};
              claimed_nxt = 1'b1;
            end
          end
          REQ_QUERY: begin
            if (expired) begin
              head_ret.valid = 1'b0;
              wr_en          = rd_in_range;
            end
          end
          REQ_NEXT: begin
            if (head.valid && (rem < best_r)) begin
              best_nxt = rem;
            end
          end
          default: begin
          end
        endcase
        if (last) begin
          scan_cnt_nxt = '0;
          case (op_r)
            REQ_QUERY: begin
              state_nxt = ST_FINISH;
            end
            REQ_START: begin
              state_nxt     = ST_IDLE;
              out_valid_nxt = 1'b1;
              out_ok_nxt    = claimed_nxt;
            end
            default: begin
              state_nxt          = ST_IDLE;
              out_valid_nxt      = 1'b1;
              out_next_ticks_nxt = best_nxt;
            end
          endcase
        end
      end

      ST_FINISH: begin
        // A handle out of range reads as zero and so reports elapsed.
        state_nxt          = ST_IDLE;
        out_valid_nxt      = 1'b1;
        out_is_elapsed_nxt = (rd_dur == '0);
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      scan_cnt_r  <= '0;
      claimed_r   <= 1'b0;
      tick_now_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_cnt_r  <= scan_cnt_nxt;
      claimed_r   <= claimed_nxt;
      tick_now_r  <= tick_now_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r             <= op_nxt;
    hid_r            <= hid_nxt;
    best_r           <= best_nxt;
    out_ok_r         <= out_ok_nxt;
    out_is_elapsed_r <= out_is_elapsed_nxt;
    out_next_ticks_r <= out_next_ticks_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_HANDLES; i++) begin
        dur_r[i] <= '0;
      end
    end else if (wr_en) begin
      dur_r[wr_addr] <= wr_data;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_is_elapsed = out_is_elapsed_r;
  assign out_next_ticks = out_next_ticks_r;

`ifndef ASSERT_OFF
  // A result is only ever shown once the controller is back at idle.
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // Every accepted item either answers at once or keeps the block busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && start && !busy) |=> (out_valid || busy))
    else $error("accepted item lost");

  // The walk counter rests at zero whenever the chain is not walking.
  a_count_rest: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_SCAN) |-> (scan_cnt_r == '0))
    else $error("walk counter not at rest");

  // The tick count moves only on an accepted tick.
  a_tick_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !(start && !busy && (in_req_type == REQ_TICK))) |=> $stable(tick_now_r))
    else $error("tick count changed without a tick");
`endif

endmodule

`default_nettype wire
